// File: hdl/wfs_pkg.sv
// Shared types and constants for the weld feeder sequencer.
// Used by wfs_seq, wfs_speed and weld_feeder_sequencer_unit; depends on nothing.
package wfs_pkg;

  localparam int unsigned CfgWidth   = 16;
  localparam int unsigned CountWidth = 16;
  localparam int unsigned AdcWidth   = 12;
  localparam int unsigned DutyWidth  = 7;
  localparam int unsigned SpeedWidth = 16;
  localparam int unsigned InWidth    = 32;
  localparam int unsigned OutWidth   = 32;

  localparam logic [CfgWidth-1:0] TrigDebounceRst  = 16'd10;
  localparam logic [CfgWidth-1:0] GasPreRst        = 16'd500;
  localparam logic [CfgWidth-1:0] WeldToMotorRst   = 16'd100;
  localparam logic [CfgWidth-1:0] BrakeToWeldRst   = 16'd100;
  localparam logic [CfgWidth-1:0] WeldOffToGasRst  = 16'd500;
  localparam logic [CfgWidth-1:0] SpeedWindowRst   = 16'd99;
  localparam logic [CfgWidth-1:0] MmPerCountRst    = 16'd256;

  // Full-scale ADC code, divisor of the duty computation.
  localparam logic [AdcWidth-1:0] AdcFullScale = 12'd4095;

  typedef enum logic [2:0] {
    PH_IDLE          = 3'd0,
    PH_GAS_WAIT      = 3'd1,
    PH_WELD_WAIT     = 3'd2,
    PH_RUNNING       = 3'd3,
    PH_BRAKE_WAIT    = 3'd4,
    PH_WELD_OFF_WAIT = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    REG_TRIG_DEBOUNCE = 3'd0,
    REG_GAS_PRE       = 3'd1,
    REG_WELD_TO_MOTOR = 3'd2,
    REG_BRAKE_TO_WELD = 3'd3,
    REG_WELD_OFF_GAS  = 3'd4,
    REG_SPEED_WINDOW  = 3'd5,
    REG_MM_PER_COUNT  = 3'd6
  } cfg_index_t;

  // Gas sits in the lowest bit when packed.
  typedef struct packed {
    logic motor;
    logic brake;
    logic weld;
    logic gas;
  } drive_t;

  typedef struct packed {
    logic [CfgWidth-1:0] trig_debounce;
    logic [CfgWidth-1:0] gas_pre;
    logic [CfgWidth-1:0] weld_to_motor;
    logic [CfgWidth-1:0] brake_to_weld;
    logic [CfgWidth-1:0] weld_off_to_gas;
  } seq_cfg_t;

endpackage

// File: hdl/wfs_seq.sv
// Start/stop sequencer with trigger debounce: phase, delay timer and drive levels.
// Depends on wfs_pkg.
module wfs_seq (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic              sw,
  input  logic              gun,
  input  logic              edge_seen,
  input  wfs_pkg::seq_cfg_t cfg,
  output wfs_pkg::phase_t   phase,
  output wfs_pkg::drive_t   drive
);
  import wfs_pkg::*;

  logic [CfgWidth-1:0] delay_left;
  logic [CfgWidth-1:0] debounce_left;
  phase_t              phase_next;
  logic [CfgWidth-1:0] delay_next;
  logic [CfgWidth-1:0] debounce_next;
  drive_t              drive_next;
  logic                timer_fire;
  logic                trig_fire;

  // Next phase, timer and debounce count.
  always_comb begin
    logic [CfgWidth-1:0] deb_load;
    logic [CfgWidth-1:0] dec;
    deb_load   = edge_seen ? cfg.trig_debounce : debounce_left;
    dec        = delay_left - 16'd1;
    phase_next = phase;
    delay_next = delay_left;
    timer_fire = 1'b0;
    unique case (phase)
      PH_GAS_WAIT, PH_WELD_WAIT, PH_BRAKE_WAIT, PH_WELD_OFF_WAIT: begin
        delay_next = dec;
        if (dec == '0) begin
          timer_fire = 1'b1;
          unique case (phase)
            PH_GAS_WAIT: begin
              phase_next = PH_WELD_WAIT;
              delay_next = cfg.weld_to_motor;
            end
            PH_WELD_WAIT:  phase_next = PH_RUNNING;
            PH_BRAKE_WAIT: begin
              phase_next = PH_WELD_OFF_WAIT;
              delay_next = cfg.weld_off_to_gas;
            end
            default:       phase_next = PH_IDLE;
          endcase
        end
      end
      PH_RUNNING: phase_next = PH_RUNNING;
      default:    phase_next = PH_IDLE;
    endcase

    debounce_next = deb_load;
    trig_fire     = 1'b0;
    if (sw && (deb_load != '0)) begin
      debounce_next = deb_load - 16'd1;
      trig_fire     = (debounce_next == '0);
    end
    if (trig_fire) begin
      if (gun) begin
        phase_next = PH_GAS_WAIT;
        delay_next = cfg.gas_pre;
      end else begin
        phase_next = PH_BRAKE_WAIT;
        delay_next = cfg.brake_to_weld;
      end
    end
  end

  // Drive levels: the timed step acts first, then a debounced trigger.
  always_comb begin
    drive_next = drive;
    if (timer_fire) begin
      unique case (phase)
        PH_GAS_WAIT:  drive_next.weld = 1'b1;
        PH_WELD_WAIT: begin
          drive_next.brake = 1'b0;
          drive_next.motor = 1'b1;
        end
        PH_BRAKE_WAIT: drive_next.weld = 1'b0;
        default:       drive_next.gas  = 1'b0;
      endcase
    end
    if (trig_fire) begin
      if (gun) begin
        drive_next.gas = 1'b1;
      end else begin
        drive_next.brake = 1'b1;
        drive_next.motor = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      delay_left    <= '0;
      debounce_left <= '0;
      drive         <= '0;
    end else if (step) begin
      phase         <= phase_next;
      delay_left    <= delay_next;
      debounce_left <= debounce_next;
      drive         <= drive_next;
    end
  end

endmodule

// File: hdl/wfs_speed.sv
// Wire speed measurement: window counter, encoder delta and Q8.8 scaling with saturation.
// Depends on wfs_pkg.
module wfs_speed (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               step,
  input  logic [wfs_pkg::CountWidth-1:0]     count,
  input  logic [wfs_pkg::CfgWidth-1:0]       window_ticks,
  input  logic [wfs_pkg::CfgWidth-1:0]       mm_per_count,
  output logic [wfs_pkg::SpeedWidth-1:0]     speed_hold,
  output logic                               speed_update
);
  import wfs_pkg::*;

  logic [CfgWidth-1:0]            window_left;
  logic [CountWidth-1:0]          last_count;
  logic [CountWidth-1:0]          delta;
  logic [CountWidth+CfgWidth-1:0] product;
  logic [SpeedWidth-1:0]          speed_sat;

  assign delta   = count - last_count;
  assign product = delta * mm_per_count;

  // The product is Q24.8; anything above bit 23 means the 16-bit result saturates.
  always_comb begin
    if (product[CountWidth+CfgWidth-1:SpeedWidth+8] != '0) begin
      speed_sat = '1;
    end else begin
      speed_sat = product[SpeedWidth+7:8];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_left  <= SpeedWindowRst;
      last_count   <= '0;
      speed_hold   <= '0;
      speed_update <= 1'b0;
    end else if (step) begin
      if (window_left == '0) begin
        window_left  <= window_ticks;
        last_count   <= count;
        speed_hold   <= speed_sat;
        speed_update <= 1'b1;
      end else begin
        window_left  <= window_left - 16'd1;
        speed_update <= 1'b0;
      end
    end
  end

endmodule

// File: hdl/weld_feeder_sequencer_unit.sv
// Top level of the weld feeder sequencer: stream ports, configuration registers,
// input register, duty computation and result handshake. Depends on wfs_pkg, wfs_seq, wfs_speed.
//
// Each beat on the slave side is one tick and produces exactly one result beat holding the
// state after that tick. The block takes one beat per clock cycle while the master side keeps up: a
// beat waits in the input register, and the sequencer, speed and duty registers then hold the
// result until the master side takes it, while the next beat already waits in the input
// register. The speed path is one 16x16 multiply per tick; the duty is adc*100/4095 rounded
// down. Configuration registers take effect on the next tick and should be written only while
// no beat is in flight.
module weld_feeder_sequencer_unit (
  input  logic                                clk,
  input  logic                                rst,
  // Configuration write port
  input  logic                                wr_en,
  input  logic [2:0]                          wr_index,
  input  logic [wfs_pkg::CfgWidth-1:0]        wr_data,
  // Tick input
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // From bit 0: switch_enabled, gun_pressed, trigger_edge, encoder_count[15:0],
  // adc_sample[11:0], one zero pad bit
  input  logic [wfs_pkg::InWidth-1:0]         s_axis_tdata,
  // Result output
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // From bit 0: gas_on, weld_on, brake_on, motor_on, duty_percent[6:0], speed_update,
  // wire_speed[15:0], phase[2:0], one zero pad bit
  output logic [wfs_pkg::OutWidth-1:0]        m_axis_tdata
);
  import wfs_pkg::*;

  seq_cfg_t             seq_cfg;
  logic [CfgWidth-1:0]  speed_window;
  logic [CfgWidth-1:0]  mm_per_count;

  logic                 in_valid;
  logic                 in_sw;
  logic                 in_gun;
  logic                 in_edge;
  logic [CountWidth-1:0] in_count;
  logic [AdcWidth-1:0]  in_adc;

  logic                 step;
  logic [DutyWidth-1:0] duty_hold;
  logic [DutyWidth-1:0] duty_calc;
  phase_t               phase;
  drive_t               drive;
  logic [SpeedWidth-1:0] speed_hold;
  logic                 speed_update;

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_cfg.trig_debounce   <= TrigDebounceRst;
      seq_cfg.gas_pre         <= GasPreRst;
      seq_cfg.weld_to_motor   <= WeldToMotorRst;
      seq_cfg.brake_to_weld   <= BrakeToWeldRst;
      seq_cfg.weld_off_to_gas <= WeldOffToGasRst;
      speed_window            <= SpeedWindowRst;
      mm_per_count            <= MmPerCountRst;
    end else if (wr_en) begin
      unique case (cfg_index_t'(wr_index))
        REG_TRIG_DEBOUNCE: seq_cfg.trig_debounce   <= wr_data;
        REG_GAS_PRE:       seq_cfg.gas_pre         <= wr_data;
        REG_WELD_TO_MOTOR: seq_cfg.weld_to_motor   <= wr_data;
        REG_BRAKE_TO_WELD: seq_cfg.brake_to_weld   <= wr_data;
        REG_WELD_OFF_GAS:  seq_cfg.weld_off_to_gas <= wr_data;
        REG_SPEED_WINDOW:  speed_window            <= wr_data;
        REG_MM_PER_COUNT:  mm_per_count            <= wr_data;
        default: ;
      endcase
    end
  end

  // The state registers double as the result register, so a tick is processed only
  // when the previous result has been taken or is being taken in this cycle.
  assign step          = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_sw    <= s_axis_tdata[0];
      in_gun   <= s_axis_tdata[1];
      in_edge  <= s_axis_tdata[2];
      in_count <= s_axis_tdata[18:3];
      in_adc   <= s_axis_tdata[30:19];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (step) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  // Divide by 4095 = 4096 - 1: take x >> 12, then the remainder is the low 12 bits plus
  // that quotient, which stays below twice the divisor, so one correction step suffices.
  always_comb begin
    logic [AdcWidth+6:0] scaled;
    logic [DutyWidth-1:0] q0;
    logic [AdcWidth:0]   rem;
    scaled = ({7'd0, in_adc} << 6) + ({7'd0, in_adc} << 5) + ({7'd0, in_adc} << 2);
    q0     = scaled[AdcWidth+6:AdcWidth];
    rem    = {1'b0, scaled[AdcWidth-1:0]} + {6'd0, q0};
    if (rem >= {1'b0, AdcFullScale}) begin
      duty_calc = q0 + 7'd1;
    end else begin
      duty_calc = q0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      duty_hold <= '0;
    end else if (step && in_sw) begin
      duty_hold <= duty_calc;
    end
  end

  wfs_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .sw        (in_sw),
    .gun       (in_gun),
    .edge_seen (in_edge),
    .cfg       (seq_cfg),
    .phase     (phase),
    .drive     (drive)
  );

  wfs_speed u_speed (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .count        (in_count),
    .window_ticks (speed_window),
    .mm_per_count (mm_per_count),
    .speed_hold   (speed_hold),
    .speed_update (speed_update)
  );

  assign m_axis_tdata = {1'b0, phase, speed_hold, speed_update, duty_hold, drive};

endmodule

// File: tb/sv/weld_feeder_sequencer_unit_tb.sv
// Self-checking testbench for weld_feeder_sequencer_unit: start and stop sequencing, duty, debounce
// and speed windows, checked beat by beat against a predictor kept in the testbench.
// Depends on wfs_pkg and the RTL of weld_feeder_sequencer_unit.
module weld_feeder_sequencer_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wfs_pkg::*;

  localparam int unsigned CycleLimit = 400000;

  typedef struct {
    logic             sw_on;
    logic             gun;
    logic             trig;
    logic [15:0]      count;
    logic [11:0]      adc;
  } tick_t;

  typedef struct {
    logic             gas;
    logic             weld;
    logic             brake;
    logic             motor;
    logic [6:0]       duty;
    logic             spd_upd;
    logic [15:0]      speed;
    phase_t           phase;
  } result_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                wr_en = 1'b0;
  logic [2:0]          wr_index = '0;
  logic [CfgWidth-1:0] wr_data = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InWidth-1:0]  s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutWidth-1:0] m_axis_tdata;

  // Predictor copy of the registers and the block state.
  logic [15:0]         reg_val [7];
  phase_t              seq_ph;
  logic [15:0]         delay_cnt;
  logic [15:0]         debounce_cnt;
  logic [15:0]         window_cnt;
  logic [15:0]         prev_count;
  logic [15:0]         speed_q;
  logic [6:0]          duty_q;
  drive_t              drives;

  result_t             expected_results [$];
  int                  fail_count = 0;
  int unsigned         cycle_count = 0;
  int                  send_idle_pct = 0;
  int                  recv_idle_pct = 0;
  int                  stall_request = 0;
  int                  stall_left = 0;

  weld_feeder_sequencer_unit DUT (
    .clk           (clk),
    .rst           (rst),
    .wr_en         (wr_en),
    .wr_index      (wr_index),
    .wr_data       (wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic void predict_tick(tick_t t);
    result_t     r;
    logic [15:0] delta;
    logic [31:0] prod;
    logic        upd;
    upd = 1'b0;
    if (t.trig) begin
      debounce_cnt = reg_val[REG_TRIG_DEBOUNCE];
    end

    case (seq_ph)
      PH_GAS_WAIT, PH_WELD_WAIT, PH_BRAKE_WAIT, PH_WELD_OFF_WAIT: begin
        delay_cnt = delay_cnt - 16'd1;
        if (delay_cnt == 16'd0) begin
          case (seq_ph)
            PH_GAS_WAIT: begin
              drives.weld = 1'b1;
              seq_ph      = PH_WELD_WAIT;
              delay_cnt   = reg_val[REG_WELD_TO_MOTOR];
            end
            PH_WELD_WAIT: begin
              drives.brake = 1'b0;
              drives.motor = 1'b1;
              seq_ph       = PH_RUNNING;
            end
            PH_BRAKE_WAIT: begin
              drives.weld = 1'b0;
              seq_ph      = PH_WELD_OFF_WAIT;
              delay_cnt   = reg_val[REG_WELD_OFF_GAS];
            end
            default: begin
              drives.gas = 1'b0;
              seq_ph     = PH_IDLE;
            end
          endcase
        end
      end
      PH_RUNNING: ;
      default: seq_ph = PH_IDLE;
    endcase

    if (window_cnt == 16'd0) begin
      delta      = t.count - prev_count;
      prod       = ({16'd0, delta} * {16'd0, reg_val[REG_MM_PER_COUNT]}) >> 8;
      speed_q    = (prod > 32'h0000_FFFF) ? 16'hFFFF : prod[15:0];
      window_cnt = reg_val[REG_SPEED_WINDOW];
      prev_count = t.count;
      upd        = 1'b1;
    end else begin
      window_cnt = window_cnt - 16'd1;
    end

    if (t.sw_on) begin
      duty_q = 7'((32'(t.adc) * 32'd100) / 32'(AdcFullScale));
      if (debounce_cnt != 16'd0) begin
        debounce_cnt = debounce_cnt - 16'd1;
        if (debounce_cnt == 16'd0) begin
          if (t.gun) begin
            drives.gas = 1'b1;
            seq_ph     = PH_GAS_WAIT;
            delay_cnt  = reg_val[REG_GAS_PRE];
          end else begin
            drives.brake = 1'b1;
            drives.motor = 1'b0;
            seq_ph       = PH_BRAKE_WAIT;
            delay_cnt    = reg_val[REG_BRAKE_TO_WELD];
          end
        end
      end
    end

    r.gas     = drives.gas;
    r.weld    = drives.weld;
    r.brake   = drives.brake;
    r.motor   = drives.motor;
    r.duty    = duty_q;
    r.spd_upd = upd;
    r.speed   = speed_q;
    r.phase   = seq_ph;
    expected_results.push_back(r);
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      fail_count++;
    end
  endfunction

  // Result side: check every accepted beat, then pick the next ready level.
  always @(posedge clk) begin
    result_t r;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        $error("result beat 0x%08h with no expected result pending", m_axis_tdata);
        fail_count++;
      end else begin
        r = expected_results.pop_front();
        check_field("gas_on", 32'(r.gas), 32'(m_axis_tdata[0]));
        check_field("weld_on", 32'(r.weld), 32'(m_axis_tdata[1]));
        check_field("brake_on", 32'(r.brake), 32'(m_axis_tdata[2]));
        check_field("motor_on", 32'(r.motor), 32'(m_axis_tdata[3]));
        check_field("duty_percent", 32'(r.duty), 32'(m_axis_tdata[10:4]));
        check_field("speed_update", 32'(r.spd_upd), 32'(m_axis_tdata[11]));
        check_field("wire_speed", 32'(r.speed), 32'(m_axis_tdata[27:12]));
        check_field("phase", 32'(r.phase), 32'(m_axis_tdata[30:28]));
      end
    end
    if (stall_request != 0) begin
      stall_left    = stall_request;
      stall_request = 0;
    end
    if (stall_left != 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Called at a rising edge; returns at the edge where the beat was taken.
  task automatic send_tick(input logic sw_on, input logic gun, input logic trig,
                           input logic [15:0] count, input logic [11:0] adc);
    tick_t t;
    t.sw_on = sw_on;
    t.gun   = gun;
    t.trig  = trig;
    t.count = count;
    t.adc   = adc;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, adc, count, trig, gun, sw_on};
    do @(posedge clk); while (!s_axis_tready);
    predict_tick(t);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_regs(input logic [15:0] deb, input logic [15:0] gas_pre,
                              input logic [15:0] weld_motor, input logic [15:0] brake_weld,
                              input logic [15:0] weld_gas, input logic [15:0] window,
                              input logic [15:0] scale);
    logic [15:0] vals [7];
    vals[REG_TRIG_DEBOUNCE] = deb;
    vals[REG_GAS_PRE]       = gas_pre;
    vals[REG_WELD_TO_MOTOR] = weld_motor;
    vals[REG_BRAKE_TO_WELD] = brake_weld;
    vals[REG_WELD_OFF_GAS]  = weld_gas;
    vals[REG_SPEED_WINDOW]  = window;
    vals[REG_MM_PER_COUNT]  = scale;
    for (int i = 0; i < 7; i++) begin
      wr_en      <= 1'b1;
      wr_index   <= cfg_index_t'(i);
      wr_data    <= vals[i];
      reg_val[i] = vals[i];
      @(posedge clk);
    end
    wr_en <= 1'b0;
  endtask

  // Full start and stop by hand, with the switch off in the middle.
  task automatic test_start_stop_sequence();
    program_regs(16'd2, 16'd2, 16'd3, 16'd2, 16'd3, 16'hFFFF, 16'd0);
    send_tick(1'b1, 1'b0, 1'b0, 16'h0000, 12'd4095);
    send_tick(1'b1, 1'b0, 1'b0, 16'hFFFF, 12'd0);
    send_tick(1'b1, 1'b0, 1'b0, 16'h5555, 12'd2048);
    send_tick(1'b1, 1'b1, 1'b1, 16'hAAAA, 12'd4094);
    for (int k = 0; k < 6; k++) begin
      send_tick(1'b1, 1'b1, 1'b0, 16'h1234 + 16'(k), 12'hAAA);
    end
    // Switch off: duty and debounce freeze, but the edge still loads.
    send_tick(1'b0, 1'b1, 1'b0, 16'h2000, 12'd100);
    send_tick(1'b0, 1'b0, 1'b1, 16'h2001, 12'd200);
    send_tick(1'b0, 1'b0, 1'b0, 16'h2002, 12'd300);
    for (int k = 0; k < 7; k++) begin
      send_tick(1'b1, 1'b0, 1'b0, 16'h3000, 12'h555);
    end
    // Stop request while already idle.
    send_tick(1'b1, 1'b0, 1'b1, 16'h4000, 12'd1);
    for (int k = 0; k < 4; k++) begin
      send_tick(1'b1, 1'b0, 1'b0, 16'h4000, 12'd41);
    end
    drain();
  endtask

  // Zero and full-scale register values: immediate debounce, a 65536-tick wait cut short by a
  // stop, a speed update on every tick with saturation and wrap, and a zero debounce load.
  task automatic test_register_extremes();
    program_regs(16'd1, 16'd0, 16'hFFFF, 16'd1, 16'd1, 16'd0, 16'hFFFF);
    send_tick(1'b1, 1'b0, 1'b0, 16'h0000, 12'd7);
    send_tick(1'b1, 1'b0, 1'b0, 16'hFFFF, 12'd7);
    send_tick(1'b1, 1'b0, 1'b0, 16'h0000, 12'd7);
    send_tick(1'b1, 1'b0, 1'b0, 16'h0001, 12'd7);
    send_tick(1'b1, 1'b0, 1'b0, 16'h0200, 12'd7);
    send_tick(1'b1, 1'b0, 1'b0, 16'h0100, 12'd7);
    send_tick(1'b1, 1'b0, 1'b0, 16'hFFFF, 12'd7);
    send_tick(1'b1, 1'b0, 1'b0, 16'h8000, 12'd7);
    send_tick(1'b1, 1'b1, 1'b1, 16'h8001, 12'd4095);
    for (int k = 0; k < 4; k++) begin
      send_tick(1'b1, 1'b1, 1'b0, 16'h8002, 12'd4095);
    end
    send_tick(1'b1, 1'b0, 1'b1, 16'h8003, 12'd0);
    for (int k = 0; k < 3; k++) begin
      send_tick(1'b1, 1'b0, 1'b0, 16'h8004, 12'd0);
    end
    drain();
    program_regs(16'd0, 16'hFFFF, 16'd1, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0);
    send_tick(1'b1, 1'b1, 1'b1, 16'h0000, 12'd4095);
    for (int k = 0; k < 5; k++) begin
      send_tick(1'b1, 1'b1, 1'b0, 16'hFFFF - 16'(k), 12'd4095);
    end
    drain();
  endtask

  // Mostly well-formed weld cycles: the gun level toggles with an edge now and then, with
  // bounces, switch-off ticks and encoder jumps mixed in.
  task automatic test_random_feed(input int n_items, input int max_delay, input int max_window,
                                  input int toggle_pm, input int stall_at);
    logic        gun_level;
    logic        trig;
    logic [15:0] enc_pos;
    logic [15:0] scale;
    gun_level = 1'b0;
    enc_pos   = 16'($urandom);
    case ($urandom_range(3))
      0:       scale = 16'd0;
      1:       scale = 16'hFFFF;
      2:       scale = 16'd256;
      default: scale = 16'($urandom);
    endcase
    program_regs(16'($urandom_range(1, 5)), 16'($urandom_range(1, max_delay)),
                 16'($urandom_range(1, max_delay)), 16'($urandom_range(1, max_delay)),
                 16'($urandom_range(1, max_delay)), 16'($urandom_range(0, max_window)), scale);
    for (int k = 0; k < n_items; k++) begin
      trig = 1'b0;
      if ($urandom_range(999) < toggle_pm) begin
        gun_level = ~gun_level;
        trig      = 1'b1;
      end else if ($urandom_range(99) < 2) begin
        trig = 1'b1;
      end
      if ($urandom_range(99) < 3) begin
        enc_pos = 16'($urandom);
      end else begin
        enc_pos = enc_pos + 16'($urandom_range(0, 40));
      end
      if (k == stall_at) begin
        stall_request = 300;
      end
      send_tick($urandom_range(99) >= 10, gun_level, trig, enc_pos,
                12'($urandom_range(4095)));
    end
    drain();
  endtask

  // The result side holds off for a long stretch while ticks keep coming.
  task automatic test_backpressure();
    test_random_feed(300, 8, 5, 40, 60);
  endtask

  initial begin
    reg_val[REG_TRIG_DEBOUNCE] = TrigDebounceRst;
    reg_val[REG_GAS_PRE]       = GasPreRst;
    reg_val[REG_WELD_TO_MOTOR] = WeldToMotorRst;
    reg_val[REG_BRAKE_TO_WELD] = BrakeToWeldRst;
    reg_val[REG_WELD_OFF_GAS]  = WeldOffToGasRst;
    reg_val[REG_SPEED_WINDOW]  = SpeedWindowRst;
    reg_val[REG_MM_PER_COUNT]  = MmPerCountRst;
    seq_ph       = PH_IDLE;
    delay_cnt    = '0;
    debounce_cnt = '0;
    window_cnt   = SpeedWindowRst;
    prev_count   = '0;
    speed_q      = '0;
    duty_q       = '0;
    drives       = '0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 9;
    recv_idle_pct = 73;
    test_start_stop_sequence();
    test_random_feed(350, 8, 7, 40, -1);
    test_register_extremes();

    send_idle_pct = 73;
    recv_idle_pct = 9;
    test_random_feed(350, 8, 5, 40, -1);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_backpressure();
    test_random_feed(350, 30, 300, 15, -1);

    repeat (6) @(posedge clk);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
